### hdl/rks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_pkg
// Shared types and constants for the recency ordered key set.
// ----------------------------------------------------------------------------
package rks_pkg;

    localparam int KEY_W = 64;
    localparam int OCC_W = 9;

    localparam logic OP_REMEMBER = 1'b0;
    localparam logic OP_CONSUME  = 1'b1;

    // per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic cmp_en;    // capture key match
        logic shift_en;  // cells at or above shift position take the neighbor key
        logic load_en;   // cell at load position takes the transaction key
    } t_cell_ctrl;

endpackage

### hdl/recency_ordered_key_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recency_ordered_key_set_unit
// Bounded set of 64-bit keys kept oldest to newest in a chain of cells.
// Remember moves a stored key to the newest slot or appends it, evicting the
// oldest key when full; consume removes a stored key and closes the gap.
//
//   channel | handshake        | payload
//   --------+------------------+------------------------------------------
//   command | start / busy     | i_operation, i_key_present, i_stamp_key
//   result  | o_done (1 cycle) | o_found, o_evicted, o_occupancy
//
// A transaction runs from accept to the next possible accept through
// capture, per-cell compare, match position encode and chain update.
// o_done pulses the cycle after the update, when busy is already low.
// Reset clears state, count and result flags; slots are don't-care until written.
// The result cannot be stalled; its payload holds until the next chain update.
// ----------------------------------------------------------------------------
module recency_ordered_key_set_unit
    import rks_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_operation,
    input  logic             i_key_present,
    input  logic [KEY_W-1:0] i_stamp_key,
    output logic             o_done,
    output logic             o_found,
    output logic             o_evicted,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ENC,
        S_UPD
    } t_state;

    t_state           r_state, n_state;
    logic             r_op;
    logic             r_present;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_hit_any;
    logic [IDX_W-1:0] r_hit_pos;
    logic             r_done, n_done;
    logic             r_found, n_found;
    logic             r_evicted, n_evicted;

    t_cell_ctrl       cell_ctrl;
    logic [IDX_W-1:0] shift_pos;
    logic [IDX_W-1:0] load_pos;
    logic [KEY_W-1:0] chain_key [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;
    logic             enc_any;
    logic [IDX_W-1:0] enc_pos;
    logic             accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // cell chain, slot 0 is the oldest
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] nbr_key;
        if (g == CAPACITY - 1) begin : g_top
            assign nbr_key = r_key;
        end else begin : g_mid
            assign nbr_key = chain_key[g+1];
        end
        rks_cell #(
            .IDX   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_key       (r_key),
            .i_nbr_key   (nbr_key),
            .i_count     (r_count),
            .i_shift_pos (shift_pos),
            .i_load_pos  (load_pos),
            .o_key       (chain_key[g]),
            .o_hit       (hit_vec[g])
        );
    end

    // at most one cell matches, so or-ing the indexes yields its position
    always_comb begin
        enc_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit_vec[i]) begin
                enc_pos = enc_pos | IDX_W'(i);
            end
        end
        enc_any = |hit_vec;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_done    = 1'b0;
        n_found   = r_found;
        n_evicted = r_evicted;
        cell_ctrl = '0;
        shift_pos = r_hit_pos;
        load_pos  = IDX_W'(r_count);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                cell_ctrl.cmp_en = 1'b1;
                n_state          = S_ENC;
            end
            S_ENC: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state   = S_IDLE;
                n_done    = 1'b1;
                n_found   = r_present && r_hit_any;
                n_evicted = 1'b0;
                if (r_present) begin
                    if (r_hit_any) begin
                        cell_ctrl.shift_en = 1'b1;
                        if (r_op == OP_REMEMBER) begin
                            cell_ctrl.load_en = 1'b1;
                            load_pos          = IDX_W'(r_count - CNT_W'(1));
                        end else begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end else if (r_op == OP_REMEMBER) begin
                        cell_ctrl.load_en = 1'b1;
                        if (r_count == CNT_W'(CAPACITY)) begin
                            // full: drop the oldest and append at the top
                            cell_ctrl.shift_en = 1'b1;
                            shift_pos          = '0;
                            load_pos           = IDX_W'(CAPACITY - 1);
                            n_evicted          = 1'b1;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_found   <= 1'b0;
            r_evicted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_done    <= n_done;
            r_found   <= n_found;
            r_evicted <= n_evicted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_operation;
            r_present <= i_key_present;
            r_key     <= i_stamp_key;
        end
        if (r_state == S_ENC) begin
            r_hit_any <= enc_any;
            r_hit_pos <= enc_pos;
        end
    end

    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_evicted   = r_evicted;
    assign o_occupancy = OCC_W'(r_count);

endmodule

### hdl/rks_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_cell
// One slot of the key chain: holds a key, flags a match against the
// broadcast key, and takes its newer neighbor's key when the chain closes up.
// ----------------------------------------------------------------------------
module rks_cell
    import rks_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
) (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [KEY_W-1:0] i_key,
    input  logic [KEY_W-1:0] i_nbr_key,
    input  logic [CNT_W-1:0] i_count,
    input  logic [IDX_W-1:0] i_shift_pos,
    input  logic [IDX_W-1:0] i_load_pos,
    output logic [KEY_W-1:0] o_key,
    output logic             o_hit
);

    logic [KEY_W-1:0] r_key;
    logic             r_hit;
    logic             slot_valid;
    logic             take_load;
    logic             take_shift;

    assign slot_valid = (CNT_W'(IDX) < i_count);
    assign take_load  = i_ctrl.load_en && (i_load_pos == IDX_W'(IDX));
    assign take_shift = i_ctrl.shift_en && (IDX_W'(IDX) >= i_shift_pos);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_hit <= slot_valid && (r_key == i_key);
        end
        // load wins over shift: the newest slot takes the key while the gap closes beneath it
        if (take_load) begin
            r_key <= i_key;
        end else if (take_shift) begin
            r_key <= i_nbr_key;
        end
    end

    assign o_key = r_key;
    assign o_hit = r_hit;

endmodule

### hdl/rks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_checker
// Port-level checks on transaction timing and result consistency.
// ----------------------------------------------------------------------------
module rks_checker
    import rks_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input logic             o_found,
    input logic             o_evicted,
    input logic [OCC_W-1:0] o_occupancy
);

    // every accepted transaction produces its result strobe once it has passed the compare, encode and update states
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("result strobe missing after accepted transaction");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a hit never evicts: the matched key is only moved or removed
    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> (!o_found && o_occupancy != '0))
        else $error("eviction reported together with a hit or empty set");

endmodule

bind recency_ordered_key_set_unit rks_checker u_rks_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_found     (o_found),
    .o_evicted   (o_evicted),
    .o_occupancy (o_occupancy)
);

### tb/tb_recency_ordered_key_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recency_ordered_key_set_unit
// Self-checking bench for the recency ordered key set. A queue of commands
// (directed corner cases, then random fill, churn, drain and small-set phases)
// feeds a bursty driver. A shadow copy of the set predicts found, evicted and
// occupancy for every accepted transaction. A monitor checks each o_done
// strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_recency_ordered_key_set_unit;
    import rks_pkg::*;

    localparam int SET_DEPTH = 256;

    typedef struct packed {
        logic             op;
        logic             present;
        logic [KEY_W-1:0] key;
        bit               hold_for_drain;
    } t_key_cmd;

    typedef struct packed {
        logic             found;
        logic             evicted;
        logic [OCC_W-1:0] occupancy;
    } t_set_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_operation = OP_REMEMBER;
    logic             i_key_present = 1'b0;
    logic [KEY_W-1:0] i_stamp_key = '0;
    logic             o_done;
    logic             o_found;
    logic             o_evicted;
    logic [OCC_W-1:0] o_occupancy;

    t_key_cmd     cmd_q[$];
    t_set_outcome outcome_q[$];
    t_key_cmd     cur_cmd;
    int           mismatch_cnt = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    bit           issue_now;

    // shadow of the set, oldest key at index 0
    logic [KEY_W-1:0] shadow_keys[SET_DEPTH];
    int               shadow_count = 0;

    recency_ordered_key_set_unit #(.CAPACITY(SET_DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_key_present(i_key_present),
        .i_stamp_key  (i_stamp_key),
        .o_done       (o_done),
        .o_found      (o_found),
        .o_evicted    (o_evicted),
        .o_occupancy  (o_occupancy)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void drop_shadow_slot(int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
        end
        shadow_count--;
    endfunction

    function automatic t_set_outcome apply_to_shadow_set(t_key_cmd c);
        t_set_outcome res;
        int           pos;
        res = '0;
        if (c.present) begin
            pos = shadow_count;
            for (int i = shadow_count - 1; i >= 0; i--) begin
                if (shadow_keys[i] == c.key) begin
                    pos = i;
                end
            end
            if (pos < shadow_count) begin
                res.found = 1'b1;
                drop_shadow_slot(pos);
                if (c.op == OP_REMEMBER) begin
                    shadow_keys[shadow_count] = c.key;
                    shadow_count++;
                end
            end else if (c.op == OP_REMEMBER) begin
                if (shadow_count >= SET_DEPTH) begin
                    res.evicted = 1'b1;
                    drop_shadow_slot(0);
                end
                shadow_keys[shadow_count] = c.key;
                shadow_count++;
            end
        end
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic push_cmd(logic op, logic present, logic [KEY_W-1:0] key, bit hold);
        t_key_cmd c;
        c.op = op;
        c.present = present;
        c.key = key;
        c.hold_for_drain = hold;
        cmd_q.push_back(c);
    endtask

    // driver: bursts of back-to-back commands separated by random idle gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                outcome_q.push_back(apply_to_shadow_set(cur_cmd));
            end
            if (!(start && busy)) begin
                issue_now = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_q.size() > 0) begin
                    issue_now = !(cmd_q[0].hold_for_drain && outcome_q.size() > 0);
                end
                if (issue_now) begin
                    cur_cmd = cmd_q.pop_front();
                    start         <= 1'b1;
                    i_operation   <= cur_cmd.op;
                    i_key_present <= cur_cmd.present;
                    i_stamp_key   <= cur_cmd.key;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(20, 40);
                            default: gap_left = $urandom_range(1, 12);
                        endcase
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_set_outcome want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("%0t unexpected result: found=%b evicted=%b occupancy=%0d",
                             $realtime, o_found, o_evicted, o_occupancy);
                end
            end else begin
                want = outcome_q.pop_front();
                if (o_found !== want.found || o_evicted !== want.evicted ||
                    o_occupancy !== want.occupancy) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $write("%0t result mismatch: expected found=%b evicted=%b ",
                               $realtime, want.found, want.evicted);
                        $display("occupancy=%0d, got found=%b evicted=%b occupancy=%0d",
                                 want.occupancy, o_found, o_evicted, o_occupancy);
                    end
                end
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] recent_keys[$];
        logic [KEY_W-1:0] churn_keys[6];
        logic [KEY_W-1:0] key;
        int               roll;
        int               pick;

        // directed: empty set, extreme keys, hits at oldest, middle and newest
        push_cmd(OP_CONSUME,  1'b0, rand_key(), 1'b0);
        push_cmd(OP_CONSUME,  1'b1, 64'h0, 1'b0);
        push_cmd(OP_REMEMBER, 1'b0, rand_key(), 1'b0);
        push_cmd(OP_REMEMBER, 1'b1, 64'h0, 1'b0);
        push_cmd(OP_REMEMBER, 1'b1, '1, 1'b0);
        push_cmd(OP_REMEMBER, 1'b1, 64'h5555_5555_5555_5555, 1'b0);
        push_cmd(OP_REMEMBER, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_cmd(OP_REMEMBER, 1'b1, 64'h0, 1'b0);
        // no key given but the value matches a stored key: must do nothing
        push_cmd(OP_REMEMBER, 1'b0, '1, 1'b0);
        push_cmd(OP_CONSUME,  1'b0, 64'h5555_5555_5555_5555, 1'b0);
        push_cmd(OP_CONSUME,  1'b1, 64'h5555_5555_5555_5555, 1'b0);
        push_cmd(OP_CONSUME,  1'b1, 64'h5555_5555_5555_5555, 1'b0);
        push_cmd(OP_CONSUME,  1'b1, '1, 1'b0);
        push_cmd(OP_REMEMBER, 1'b1, 64'h1, 1'b0);
        push_cmd(OP_REMEMBER, 1'b1, 64'h8000_0000_0000_0000, 1'b0);
        push_cmd(OP_CONSUME,  1'b1, 64'h0, 1'b0);
        push_cmd(OP_CONSUME,  1'b1, 64'h8000_0000_0000_0000, 1'b0);
        push_cmd(OP_CONSUME,  1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_cmd(OP_CONSUME,  1'b1, 64'h1, 1'b0);

        // fill past capacity so the oldest keys get evicted
        for (int n = 0; n < 300; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 90 || recent_keys.size() == 0) begin
                key = rand_key();
                recent_keys.push_back(key);
                push_cmd(OP_REMEMBER, 1'b1, key, n == 0);
            end else if (roll < 95) begin
                pick = $urandom_range(0, recent_keys.size() - 1);
                push_cmd(OP_REMEMBER, 1'b1, recent_keys[pick], 1'b0);
            end else begin
                push_cmd(logic'($urandom_range(0, 1)), 1'b0, rand_key(), 1'b0);
            end
        end

        // churn around a full set: refresh, append, remove, near misses
        for (int n = 0; n < 450; n++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, recent_keys.size() - 1);
            if (roll < 45) begin
                push_cmd(OP_REMEMBER, 1'b1, recent_keys[pick], n == 0);
            end else if (roll < 65) begin
                key = rand_key();
                recent_keys.push_back(key);
                if (recent_keys.size() > 400) begin
                    void'(recent_keys.pop_front());
                end
                push_cmd(OP_REMEMBER, 1'b1, key, n == 0);
            end else if (roll < 85) begin
                push_cmd(OP_CONSUME, 1'b1, recent_keys[pick], n == 0);
            end else if (roll < 90) begin
                // one flipped bit must never match
                key = recent_keys[pick];
                key[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
                push_cmd(logic'($urandom_range(0, 1)), 1'b1, key, n == 0);
            end else begin
                push_cmd(logic'($urandom_range(0, 1)), 1'b0, recent_keys[pick], n == 0);
            end
        end

        // drain down toward empty
        for (int n = 0; n < 330; n++) begin
            roll = $urandom_range(0, 99);
            if (recent_keys.size() == 0) begin
                push_cmd(OP_CONSUME, 1'b1, rand_key(), n == 0);
            end else if (roll < 85) begin
                pick = $urandom_range(0, recent_keys.size() - 1);
                push_cmd(OP_CONSUME, 1'b1, recent_keys[pick], n == 0);
                recent_keys.delete(pick);
            end else if (roll < 95) begin
                pick = $urandom_range(0, recent_keys.size() - 1);
                push_cmd(OP_REMEMBER, 1'b1, recent_keys[pick], n == 0);
            end else begin
                push_cmd(logic'($urandom_range(0, 1)), 1'b0, rand_key(), n == 0);
            end
        end

        // a handful of keys reused over and over at low occupancy
        foreach (churn_keys[j]) begin
            churn_keys[j] = rand_key();
        end
        for (int n = 0; n < 250; n++) begin
            push_cmd(logic'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
                     churn_keys[$urandom_range(0, 5)], n == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() > 0 || start || outcome_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
